// File: hw/rtl/nrph_pkg.sv
package nrph_pkg;

  // Number format and table sizes.
  localparam int FRAC_BITS   = 16;
  localparam int MAX_FACES   = 64;
  localparam int MAX_CORNERS = 4;
  localparam int FACE_W      = $clog2(MAX_FACES);
  localparam int CORNER_W    = $clog2(MAX_CORNERS);
  localparam int CNT_W       = 3;
  localparam int COUNT_W     = 7;
  localparam int COORD_W     = 32;
  localparam int TDATA_W     = 216;

  // Datapath widths.
  localparam int PROD_W    = 2 * COORD_W - FRAC_BITS;
  localparam int SUM_W     = PROD_W + 4;
  localparam int QUO_W     = COORD_W - 1;
  localparam int PRE_SHIFT = QUO_W - FRAC_BITS;
  localparam int C_W       = PROD_W + 2;
  localparam int DIFF_W    = C_W + 1;
  localparam int EDGE_W    = COORD_W + 1;
  localparam int LO_W      = 26;
  localparam int HI_W      = DIFF_W - LO_W;
  localparam int TERM_W    = EDGE_W + DIFF_W + 2;

  // Largest |dn| that still counts as parallel to the plane.
  localparam logic [SUM_W-1:0] NEAR_LIMIT = SUM_W'(((1 << FRAC_BITS) - 1) / 10000);
  localparam logic [COORD_W-1:0] TIME_MAX = {1'b0, {(COORD_W - 1){1'b1}}};
  localparam logic [COORD_W-1:0] NO_HIT_TIME = ~COORD_W'((1 << FRAC_BITS) - 1);

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef enum logic [1:0] {
    OP_VERTEX = 2'd0,
    OP_PLANE  = 2'd1,
    OP_CAST   = 2'd2,
    OP_SPARE  = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_t;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_ISSUE = 2'd1,
    ST_DRAIN = 2'd2
  } seq_state_t;

  // One face slot moving down the pipeline.
  typedef struct packed {
    logic              valid;
    logic              last;
    logic [FACE_W-1:0] face;
  } tok_t;

  // Face table write request.
  typedef struct packed {
    logic                vertex_we;
    logic                plane_we;
    logic [FACE_W-1:0]   face;
    logic [CORNER_W-1:0] corner;
    logic [CNT_W-1:0]    corners;
    axis_t               axis;
    coord_t              x;
    coord_t              y;
    coord_t              z;
    coord_t              offset;
  } face_wr_t;

endpackage

// File: hw/rtl/nearest_ray_polygon_hit_top.sv
// Channel    Direction  Handshake                      Payload
// s_axis     in         s_axis_tvalid / s_axis_tready  tuser opcode, tdata request fields
// m_axis     out        m_axis_tvalid / m_axis_tready  tuser hit, tdata hit_time
// cfg        in         cfg_we                         cfg_wdata face_count
//
// A cast issues one face slot per cycle, L = max(min(face_count, 64), 1) slots,
// into a 41-stage face-test pipeline whose longest part is the 32-stage divider.
// One request is in flight at a time; the next is taken once the result has been
// handed off. Reset is synchronous and clears control state and face_count; the
// face tables hold no reset value. An output stall holds the result.
module nearest_ray_polygon_hit_top import nrph_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  // face_index, vertex_index, vertex_count, first_x, first_y, first_z,
  // second_x, second_y, second_z, skip_face, zero pad
  input  logic [TDATA_W-1:0] s_axis_tdata,
  // opcode
  input  logic [1:0]         s_axis_tuser,
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  // hit_time
  output logic [COORD_W-1:0] m_axis_tdata,
  // hit
  output logic               m_axis_tuser,
  input  logic               cfg_we,
  input  logic [COUNT_W-1:0] cfg_wdata
);

  opcode_t             op;
  logic [FACE_W-1:0]   face_index;
  logic [CORNER_W-1:0] vertex_index;
  logic [CNT_W-1:0]    vertex_count;
  coord_t              first [3];
  coord_t              second [3];
  logic [COUNT_W-1:0]  skip_face;

  seq_state_t         state, state_next;
  logic [COUNT_W-1:0] face_count;
  logic [COUNT_W-1:0] slot, last_slot, limit, skip;
  logic [COUNT_W-1:0] limit_next;
  coord_t             start [3];
  coord_t             delta [3];
  logic signed [COORD_W:0] diff [3];
  logic               accept, cast_accept, issuing;
  face_wr_t           wr;
  logic [COORD_W:0]   mx, my, mz;
  tok_t               tok_issue, tok_p, tok_q, tok_e;
  logic               ok_p, ok_q, pass_e;
  logic [SUM_W-1:0]   mag_sv, mag_dn;
  logic [COORD_W-1:0] quot, time_e;
  logic               found, found_next, take;
  logic [COORD_W-1:0] best, best_next;

  // Request field unpacking.
  assign op           = opcode_t'(s_axis_tuser);
  assign face_index   = s_axis_tdata[5:0];
  assign vertex_index = s_axis_tdata[7:6];
  assign vertex_count = s_axis_tdata[10:8];
  assign first[0]     = s_axis_tdata[42:11];
  assign first[1]     = s_axis_tdata[74:43];
  assign first[2]     = s_axis_tdata[106:75];
  assign second[0]    = s_axis_tdata[138:107];
  assign second[1]    = s_axis_tdata[170:139];
  assign second[2]    = s_axis_tdata[202:171];
  assign skip_face    = s_axis_tdata[209:203];

  assign accept      = s_axis_tvalid && s_axis_tready;
  assign cast_accept = accept && (op == OP_CAST);

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      face_count <= '0;
    end else if (cfg_we) begin
      face_count <= cfg_wdata;
    end
  end

  // Table writes; the dominant axis is the largest normal magnitude.
  always_comb begin
    mx = first[0][COORD_W-1] ? -{first[0][COORD_W-1], first[0]} : {1'b0, first[0]};
    my = first[1][COORD_W-1] ? -{first[1][COORD_W-1], first[1]} : {1'b0, first[1]};
    mz = first[2][COORD_W-1] ? -{first[2][COORD_W-1], first[2]} : {1'b0, first[2]};
    wr.vertex_we = accept && (op == OP_VERTEX);
    wr.plane_we  = accept && (op == OP_PLANE);
    wr.face      = face_index;
    wr.corner    = vertex_index;
    wr.corners   = (vertex_count > CNT_W'(MAX_CORNERS)) ? CNT_W'(MAX_CORNERS) : vertex_count;
    priority if ((my < mx) && (mz < mx)) begin
      wr.axis = AXIS_X;
    end else if ((mx < my) && (mz < my)) begin
      wr.axis = AXIS_Y;
    end else begin
      wr.axis = AXIS_Z;
    end
    wr.x      = first[0];
    wr.y      = first[1];
    wr.z      = first[2];
    wr.offset = second[0];
  end

  // Segment direction, saturated to the coordinate range.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      diff[i] = second[i] - first[i];
    end
    limit_next = (face_count > COUNT_W'(MAX_FACES)) ? COUNT_W'(MAX_FACES) : face_count;
  end

  // Cast request capture.
  always_ff @(posedge clk) begin
    if (cast_accept) begin
      for (int i = 0; i < 3; i++) begin
        start[i] <= first[i];
        if (diff[i][COORD_W] != diff[i][COORD_W-1]) begin
          delta[i] <= diff[i][COORD_W] ? ~TIME_MAX : TIME_MAX;
        end else begin
          delta[i] <= diff[i][COORD_W-1:0];
        end
      end
      skip      <= skip_face;
      limit     <= limit_next;
      last_slot <= (limit_next == '0) ? '0 : limit_next - 1'b1;
    end
  end

  // Sequencer state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      slot  <= '0;
    end else begin
      state <= state_next;
      if (cast_accept) begin
        slot <= '0;
      end else if (issuing) begin
        slot <= slot + 1'b1;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (cast_accept) begin
          state_next = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        if (slot == last_slot) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (tok_e.last) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    issuing       = 1'b0;
    unique case (state)
      ST_IDLE:  s_axis_tready = !m_axis_tvalid;
      ST_ISSUE: issuing = 1'b1;
      ST_DRAIN: issuing = 1'b0;
      default: begin
        s_axis_tready = 1'b0;
        issuing       = 1'b0;
      end
    endcase
  end

  // Face slot issue; the skipped face and the empty-table slot test nothing.
  always_comb begin
    tok_issue.valid = issuing && (slot < limit) && (slot != skip);
    tok_issue.last  = issuing && (slot == last_slot);
    tok_issue.face  = slot[FACE_W-1:0];
  end

  nrph_plane u_plane (
    .clk     (clk),
    .rst     (rst),
    .wr      (wr),
    .tok_in  (tok_issue),
    .start   (start),
    .delta   (delta),
    .tok_out (tok_p),
    .ok      (ok_p),
    .mag_sv  (mag_sv),
    .mag_dn  (mag_dn)
  );

  nrph_div u_div (
    .clk      (clk),
    .rst      (rst),
    .tok_in   (tok_p),
    .ok_in    (ok_p),
    .dividend (mag_sv),
    .divisor  (mag_dn),
    .tok_out  (tok_q),
    .ok_out   (ok_q),
    .quot     (quot)
  );

  nrph_edge u_edge (
    .clk      (clk),
    .rst      (rst),
    .wr       (wr),
    .tok_in   (tok_q),
    .ok_in    (ok_q),
    .time_in  (quot),
    .start    (start),
    .delta    (delta),
    .tok_out  (tok_e),
    .pass     (pass_e),
    .hit_time (time_e)
  );

  // Nearest hit; only a strictly smaller time replaces the best.
  always_comb begin
    take       = tok_e.valid && pass_e && (!found || (time_e < best));
    found_next = found || take;
    best_next  = take ? time_e : best;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
    end else if (cast_accept) begin
      found <= 1'b0;
    end else begin
      found <= found_next;
    end
    best <= best_next;
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (tok_e.last) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
    if (tok_e.last) begin
      m_axis_tuser <= found_next;
      m_axis_tdata <= found_next ? best_next : NO_HIT_TIME;
    end
  end

  // A result appears only when the closing slot leaves the pipeline.
  a_result_from_last: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(tok_e.last))
    else $error("result raised without closing slot");

  // Face slots enter the pipeline only while issuing.
  a_issue_state: assert property (@(posedge clk) disable iff (rst)
    (tok_issue.valid || tok_issue.last) |-> (state == ST_ISSUE))
    else $error("face slot issued outside issue state");

  // A cast request starts issuing on the next cycle.
  a_cast_starts: assert property (@(posedge clk) disable iff (rst)
    cast_accept |=> (state == ST_ISSUE) && (slot == '0))
    else $error("cast did not start issuing");

endmodule

// File: hw/rtl/nrph_plane.sv
module nrph_plane import nrph_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  face_wr_t         wr,
  input  tok_t             tok_in,
  input  coord_t           start [3],
  input  coord_t           delta [3],
  output tok_t             tok_out,
  output logic             ok,
  output logic [SUM_W-1:0] mag_sv,
  output logic [SUM_W-1:0] mag_dn
);

  coord_t nx_mem [MAX_FACES];
  coord_t ny_mem [MAX_FACES];
  coord_t nz_mem [MAX_FACES];
  coord_t dist_mem [MAX_FACES];

  coord_t nrm [3];
  coord_t dist_rd;
  tok_t   tok1, tok2, tok3;

  logic signed [2*COORD_W-1:0] full_s [3];
  logic signed [2*COORD_W-1:0] full_d [3];
  logic signed [PROD_W-1:0]    ps [3];
  logic signed [PROD_W-1:0]    pd [3];
  coord_t                      dist2;
  logic signed [SUM_W-1:0]     sv_next, dn_next;
  logic signed [SUM_W-1:0]     sv, dn;

  // Plane table write and registered read.
  always_ff @(posedge clk) begin
    if (wr.plane_we) begin
      nx_mem[wr.face]   <= wr.x;
      ny_mem[wr.face]   <= wr.y;
      nz_mem[wr.face]   <= wr.z;
      dist_mem[wr.face] <= wr.offset;
    end
    nrm[0]  <= nx_mem[tok_in.face];
    nrm[1]  <= ny_mem[tok_in.face];
    nrm[2]  <= nz_mem[tok_in.face];
    dist_rd <= dist_mem[tok_in.face];
  end

  // Start and direction against the normal, floored to the fixed-point grid.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      full_s[i] = start[i] * nrm[i];
      full_d[i] = delta[i] * nrm[i];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      ps[i] <= full_s[i][2*COORD_W-1:FRAC_BITS];
      pd[i] <= full_d[i][2*COORD_W-1:FRAC_BITS];
    end
    dist2 <= dist_rd;
  end

  // Signed distance of the start point and the rate along the segment.
  always_comb begin
    sv_next = ps[0] + ps[1] + ps[2] - dist2;
    dn_next = pd[0] + pd[1] + pd[2];
  end

  always_ff @(posedge clk) begin
    sv <= sv_next;
    dn <= dn_next;
  end

  // Magnitudes and the early rejects: near-parallel, or time not positive.
  always_ff @(posedge clk) begin
    mag_sv <= sv[SUM_W-1] ? $unsigned(-sv) : $unsigned(sv);
    mag_dn <= dn[SUM_W-1] ? $unsigned(-dn) : $unsigned(dn);
    ok     <= tok3.valid && (sv != '0) && (sv[SUM_W-1] != dn[SUM_W-1]) &&
              ((dn[SUM_W-1] ? $unsigned(-dn) : $unsigned(dn)) > NEAR_LIMIT);
  end

  // Slot tokens.
  always_ff @(posedge clk) begin
    if (rst) begin
      tok1    <= '0;
      tok2    <= '0;
      tok3    <= '0;
      tok_out <= '0;
    end else begin
      tok1    <= tok_in;
      tok2    <= tok1;
      tok3    <= tok2;
      tok_out <= tok3;
    end
  end

endmodule

// File: hw/rtl/nrph_div.sv
module nrph_div import nrph_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  tok_t               tok_in,
  input  logic               ok_in,
  input  logic [SUM_W-1:0]   dividend,
  input  logic [SUM_W-1:0]   divisor,
  output tok_t               tok_out,
  output logic               ok_out,
  output logic [COORD_W-1:0] quot
);

  // Restoring divider, one quotient bit per stage.
  tok_t             tok [QUO_W+1];
  logic             okr [QUO_W+1];
  logic             ovf [QUO_W+1];
  logic [SUM_W-1:0] rem [QUO_W+1];
  logic [SUM_W-1:0] dvs [QUO_W+1];
  logic [QUO_W-1:0] nb  [QUO_W+1];
  logic [QUO_W-1:0] q   [QUO_W+1];

  // Entry stage: overflow check and the top bits of the scaled dividend.
  always_ff @(posedge clk) begin
    if (rst) begin
      tok[0] <= '0;
    end else begin
      tok[0] <= tok_in;
    end
    okr[0] <= ok_in;
    ovf[0] <= ({{PRE_SHIFT{1'b0}}, dividend} >= {divisor, {PRE_SHIFT{1'b0}}});
    rem[0] <= dividend >> PRE_SHIFT;
    nb[0]  <= {dividend[PRE_SHIFT-1:0], {FRAC_BITS{1'b0}}};
    dvs[0] <= divisor;
    q[0]   <= '0;
  end

  for (genvar g = 0; g < QUO_W; g++) begin : g_step
    logic [SUM_W:0] trial;
    assign trial = {rem[g], nb[g][QUO_W-1]};

    always_ff @(posedge clk) begin
      if (rst) begin
        tok[g+1] <= '0;
      end else begin
        tok[g+1] <= tok[g];
      end
      okr[g+1] <= okr[g];
      ovf[g+1] <= ovf[g];
      dvs[g+1] <= dvs[g];
      nb[g+1]  <= {nb[g][QUO_W-2:0], 1'b0};
      if (trial >= {1'b0, dvs[g]}) begin
        rem[g+1] <= SUM_W'(trial - {1'b0, dvs[g]});
        q[g+1]   <= {q[g][QUO_W-2:0], 1'b1};
      end else begin
        rem[g+1] <= trial[SUM_W-1:0];
        q[g+1]   <= {q[g][QUO_W-2:0], 1'b0};
      end
    end
  end

  // A quotient beyond the format saturates.
  assign tok_out = tok[QUO_W];
  assign ok_out  = okr[QUO_W];
  assign quot    = ovf[QUO_W] ? TIME_MAX : {1'b0, q[QUO_W]};

endmodule

// File: hw/rtl/nrph_edge.sv
module nrph_edge import nrph_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  face_wr_t           wr,
  input  tok_t               tok_in,
  input  logic               ok_in,
  input  logic [COORD_W-1:0] time_in,
  input  coord_t             start [3],
  input  coord_t             delta [3],
  output tok_t               tok_out,
  output logic               pass,
  output logic [COORD_W-1:0] hit_time
);

  coord_t           vx_mem [MAX_CORNERS][MAX_FACES];
  coord_t           vy_mem [MAX_CORNERS][MAX_FACES];
  coord_t           vz_mem [MAX_CORNERS][MAX_FACES];
  logic [CNT_W-1:0] cnt_mem [MAX_FACES];
  axis_t            axis_mem [MAX_FACES];

  // Stage A
  tok_t                     tok_a;
  logic                     ok_a;
  logic [COORD_W-1:0]       q_a;
  logic signed [2*COORD_W-1:0] full_c [3];
  logic signed [PROD_W-1:0] cprod_a [3];
  coord_t                   vx_a [MAX_CORNERS];
  coord_t                   vy_a [MAX_CORNERS];
  coord_t                   vz_a [MAX_CORNERS];
  logic [CNT_W-1:0]         cnt_a;
  axis_t                    axis_a;

  // Stage B
  tok_t                     tok_b;
  logic                     ok_b;
  logic [COORD_W-1:0]       q_b;
  logic signed [C_W-1:0]    c_b [3];
  coord_t                   vx_b [MAX_CORNERS];
  coord_t                   vy_b [MAX_CORNERS];
  coord_t                   vz_b [MAX_CORNERS];
  logic [CNT_W-1:0]         cnt_b;
  axis_t                    axis_b;

  // Stage C
  logic signed [C_W-1:0]    cu, cv;
  coord_t                   au [MAX_CORNERS];
  coord_t                   av [MAX_CORNERS];
  logic signed [EDGE_W-1:0] nu_next [MAX_CORNERS];
  logic signed [EDGE_W-1:0] nv_next [MAX_CORNERS];
  logic signed [DIFF_W-1:0] du_next [MAX_CORNERS];
  logic signed [DIFF_W-1:0] dv_next [MAX_CORNERS];
  tok_t                     tok_c;
  logic                     ok_c;
  logic [COORD_W-1:0]       q_c;
  logic signed [EDGE_W-1:0] nu_c [MAX_CORNERS];
  logic signed [EDGE_W-1:0] nv_c [MAX_CORNERS];
  logic signed [DIFF_W-1:0] du_c [MAX_CORNERS];
  logic signed [DIFF_W-1:0] dv_c [MAX_CORNERS];
  logic [MAX_CORNERS-1:0]   act_c;

  // Stage D
  tok_t                           tok_d;
  logic                           ok_d;
  logic [COORD_W-1:0]             q_d;
  logic [MAX_CORNERS-1:0]         act_d;
  logic signed [EDGE_W+LO_W:0]    pul_d [MAX_CORNERS];
  logic signed [EDGE_W+HI_W-1:0]  puh_d [MAX_CORNERS];
  logic signed [EDGE_W+LO_W:0]    pvl_d [MAX_CORNERS];
  logic signed [EDGE_W+HI_W-1:0]  pvh_d [MAX_CORNERS];

  // Stage E
  logic signed [TERM_W-1:0] hu [MAX_CORNERS];
  logic signed [TERM_W-1:0] hv [MAX_CORNERS];
  logic signed [TERM_W-1:0] tot [MAX_CORNERS];
  logic [MAX_CORNERS-1:0]   bad;

  // Corner and face shape tables.
  always_ff @(posedge clk) begin
    for (int k = 0; k < MAX_CORNERS; k++) begin
      if (wr.vertex_we && (wr.corner == CORNER_W'(k))) begin
        vx_mem[k][wr.face] <= wr.x;
        vy_mem[k][wr.face] <= wr.y;
        vz_mem[k][wr.face] <= wr.z;
      end
      vx_a[k] <= vx_mem[k][tok_in.face];
      vy_a[k] <= vy_mem[k][tok_in.face];
      vz_a[k] <= vz_mem[k][tok_in.face];
    end
    if (wr.plane_we) begin
      cnt_mem[wr.face]  <= wr.corners;
      axis_mem[wr.face] <= wr.axis;
    end
    cnt_a  <= cnt_mem[tok_in.face];
    axis_a <= axis_mem[tok_in.face];
  end

  // Stage A: step along the segment by the hit time.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      full_c[i] = delta[i] * $signed(time_in);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      cprod_a[i] <= full_c[i][2*COORD_W-1:FRAC_BITS];
    end
    ok_a <= ok_in && (time_in != '0);
    q_a  <= time_in;
  end

  // Stage B: hit point.
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      c_b[i] <= start[i] + cprod_a[i];
    end
    vx_b   <= vx_a;
    vy_b   <= vy_a;
    vz_b   <= vz_a;
    cnt_b  <= cnt_a;
    axis_b <= axis_a;
    ok_b   <= ok_a;
    q_b    <= q_a;
  end

  // Stage C: project onto the plane that drops the dominant axis.
  always_comb begin
    int j;
    j = 0;
    unique case (axis_b)
      AXIS_X: begin
        cu = c_b[1];
        cv = c_b[2];
        au = vy_b;
        av = vz_b;
      end
      AXIS_Y: begin
        cu = c_b[0];
        cv = c_b[2];
        au = vx_b;
        av = vz_b;
      end
      default: begin
        cu = c_b[0];
        cv = c_b[1];
        au = vx_b;
        av = vy_b;
      end
    endcase
    for (int k = 0; k < MAX_CORNERS; k++) begin
      // The last active edge closes back to the first corner.
      if ((CNT_W'(k + 1) == cnt_b) || (k == MAX_CORNERS - 1)) begin
        j = 0;
      end else begin
        j = k + 1;
      end
      nu_next[k] = av[k] - av[j];
      nv_next[k] = au[j] - au[k];
      du_next[k] = cu - au[k];
      dv_next[k] = cv - av[k];
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < MAX_CORNERS; k++) begin
      nu_c[k]  <= nu_next[k];
      nv_c[k]  <= nv_next[k];
      du_c[k]  <= du_next[k];
      dv_c[k]  <= dv_next[k];
      act_c[k] <= (CNT_W'(k) < cnt_b);
    end
    ok_c <= ok_b;
    q_c  <= q_b;
  end

  // Stage D: edge products split into low and high partial products.
  always_ff @(posedge clk) begin
    for (int k = 0; k < MAX_CORNERS; k++) begin
      pul_d[k] <= nu_c[k] * $signed({1'b0, du_c[k][LO_W-1:0]});
      puh_d[k] <= nu_c[k] * $signed(du_c[k][DIFF_W-1:LO_W]);
      pvl_d[k] <= nv_c[k] * $signed({1'b0, dv_c[k][LO_W-1:0]});
      pvh_d[k] <= nv_c[k] * $signed(dv_c[k][DIFF_W-1:LO_W]);
    end
    act_d <= act_c;
    ok_d  <= ok_c;
    q_d   <= q_c;
  end

  // Stage E: the hit point must not lie on the outer side of any edge.
  always_comb begin
    for (int k = 0; k < MAX_CORNERS; k++) begin
      hu[k]  = puh_d[k];
      hv[k]  = pvh_d[k];
      tot[k] = (hu[k] <<< LO_W) + pul_d[k] + (hv[k] <<< LO_W) + pvl_d[k];
      bad[k] = act_d[k] && tot[k][TERM_W-1];
    end
  end

  always_ff @(posedge clk) begin
    pass     <= ok_d && (bad == '0);
    hit_time <= q_d;
  end

  // Slot tokens.
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_a   <= '0;
      tok_b   <= '0;
      tok_c   <= '0;
      tok_d   <= '0;
      tok_out <= '0;
    end else begin
      tok_a   <= tok_in;
      tok_b   <= tok_a;
      tok_c   <= tok_b;
      tok_d   <= tok_c;
      tok_out <= tok_d;
    end
  end

endmodule

// File: tb/sv/nearest_ray_polygon_hit_checker.sv
module nearest_ray_polygon_hit_checker import nrph_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_axis_tvalid,
  input  logic               s_axis_tready,
  input  logic [TDATA_W-1:0] s_axis_tdata,
  input  logic [1:0]         s_axis_tuser,
  input  logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  input  logic [COORD_W-1:0] m_axis_tdata,
  input  logic               m_axis_tuser,
  input  logic               cfg_we,
  input  logic [COUNT_W-1:0] cfg_wdata,
  output int                 fail_count,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic         hit;
    logic [31:0]  hit_time;
  } cast_answer_t;

  cast_answer_t answers[$];

  // Local copy of the face table and the face count.
  longint vx[MAX_FACES*MAX_CORNERS], vy[MAX_FACES*MAX_CORNERS], vz[MAX_FACES*MAX_CORNERS];
  longint nx[MAX_FACES], ny[MAX_FACES], nz[MAX_FACES], pd[MAX_FACES];
  int     corners[MAX_FACES];
  axis_t  dom[MAX_FACES];
  int     faces_tested;

  // Fixed-point product, floored back to the number format.
  function automatic longint fx_mul(longint a, longint b);
    longint p;
    p = a * b;
    return p >>> FRAC_BITS;
  endfunction

  function automatic longint pick(longint x, longint y, longint z, int axis);
    return axis == 0 ? x : (axis == 1 ? y : z);
  endfunction

  // Returns the positive hit time of one face, or zero when the face is missed.
  function automatic longint face_hit_time(int f, longint s[3], longint d[3]);
    longint sv, dn, c[3], au, av, bu, bv;
    longint unsigned ua, ub, qi, r, q;
    logic signed [127:0] acc;
    int u, v, n, j, base;
    sv = fx_mul(s[0], nx[f]) + fx_mul(s[1], ny[f]) + fx_mul(s[2], nz[f]) - pd[f];
    dn = fx_mul(d[0], nx[f]) + fx_mul(d[1], ny[f]) + fx_mul(d[2], nz[f]);
    ub = dn < 0 ? -dn : dn;
    if (ub <= (((1 << FRAC_BITS) - 1) / 10000)) return 0;
    if (sv == 0 || ((sv < 0) == (dn < 0))) return 0;
    ua = sv < 0 ? -sv : sv;
    qi = ua / ub;
    r = ua % ub;
    if (qi > (64'h7FFFFFFF >> FRAC_BITS)) begin
      q = 64'h7FFFFFFF;
    end else begin
      q = qi;
      for (int i = 0; i < FRAC_BITS; i++) begin
        r = r << 1;
        q = q << 1;
        if (r >= ub) begin
          r = r - ub;
          q = q | 1;
        end
      end
    end
    if (q == 0) return 0;
    for (int i = 0; i < 3; i++) c[i] = s[i] + fx_mul(d[i], longint'(q));
    u = dom[f] == AXIS_X ? 1 : 0;
    v = dom[f] == AXIS_Z ? 1 : 2;
    n = corners[f];
    base = f * MAX_CORNERS;
    // Inside test against each edge in the projected plane.
    for (int k = 0; k < n; k++) begin
      j = (k == n - 1) ? 0 : k + 1;
      au = pick(vx[base+k], vy[base+k], vz[base+k], u);
      av = pick(vx[base+k], vy[base+k], vz[base+k], v);
      bu = pick(vx[base+j], vy[base+j], vz[base+j], u);
      bv = pick(vx[base+j], vy[base+j], vz[base+j], v);
      acc = 128'(signed'(av - bv)) * 128'(signed'(c[u] - au)) +
            128'(signed'(bu - au)) * 128'(signed'(c[v] - av));
      if (acc < 0) return 0;
    end
    return longint'(q);
  endfunction

  function automatic cast_answer_t nearest_hit(logic [TDATA_W-1:0] req);
    longint s[3], d[3], best, t;
    int skip, lim;
    cast_answer_t ans;
    for (int i = 0; i < 3; i++) begin
      s[i] = longint'(coord_t'(req[11 + 32*i +: 32]));
      d[i] = longint'(coord_t'(req[107 + 32*i +: 32])) - s[i];
      if (d[i] > 64'sh7FFFFFFF) d[i] = 64'sh7FFFFFFF;
      if (d[i] < -64'sh80000000) d[i] = -64'sh80000000;
    end
    skip = int'(req[209:203]);
    lim = faces_tested > MAX_FACES ? MAX_FACES : faces_tested;
    best = 0;
    for (int f = 0; f < lim; f++) begin
      if (f == skip) continue;
      t = face_hit_time(f, s, d);
      if (t > 0 && (best == 0 || t < best)) best = t;
    end
    ans.hit = best != 0;
    ans.hit_time = best != 0 ? best[31:0] : NO_HIT_TIME;
    return ans;
  endfunction

  // Track accepted requests and configuration writes.
  always @(posedge clk) begin
    longint ax, ay, az;
    int fi;
    if (rst) begin
      faces_tested = 0;
    end else begin
      if (cfg_we) faces_tested = int'(cfg_wdata);
      if (s_axis_tvalid && s_axis_tready) begin
        fi = int'(s_axis_tdata[5:0]);
        ax = longint'(coord_t'(s_axis_tdata[42:11]));
        ay = longint'(coord_t'(s_axis_tdata[74:43]));
        az = longint'(coord_t'(s_axis_tdata[106:75]));
        case (opcode_t'(s_axis_tuser))
          OP_VERTEX: begin
            vx[fi*MAX_CORNERS + int'(s_axis_tdata[7:6])] = ax;
            vy[fi*MAX_CORNERS + int'(s_axis_tdata[7:6])] = ay;
            vz[fi*MAX_CORNERS + int'(s_axis_tdata[7:6])] = az;
          end
          OP_PLANE: begin
            nx[fi] = ax;
            ny[fi] = ay;
            nz[fi] = az;
            pd[fi] = longint'(coord_t'(s_axis_tdata[138:107]));
            corners[fi] = int'(s_axis_tdata[10:8]) > MAX_CORNERS ? MAX_CORNERS :
                          int'(s_axis_tdata[10:8]);
            if (ay*ay < ax*ax && az*az < ax*ax) dom[fi] = AXIS_X;
            else if (ax*ax < ay*ay && az*az < ay*ay) dom[fi] = AXIS_Y;
            else dom[fi] = AXIS_Z;
          end
          OP_CAST: answers.insert(answers.size(), nearest_hit(s_axis_tdata));
          default: ;
        endcase
      end
    end
  end

  // Compare each returned result with the oldest expectation.
  always @(posedge clk) begin
    cast_answer_t exp_ans;
    if (rst) begin
      fail_count <= 0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      if (answers.size() == 0) begin
        if (fail_count < 10) $display("Unexpected result hit=%0b time=%h", m_axis_tuser,
                                      m_axis_tdata);
        fail_count <= fail_count + 1;
      end else begin
        exp_ans = answers.pop_front();
        if (exp_ans.hit !== m_axis_tuser || exp_ans.hit_time !== m_axis_tdata) begin
          if (fail_count < 10)
            $display("Mismatch: expected hit=%0b time=%h, got hit=%0b time=%h",
                     exp_ans.hit, exp_ans.hit_time, m_axis_tuser, m_axis_tdata);
          fail_count <= fail_count + 1;
        end
      end
    end
  end

  assign pending = answers.size();

endmodule

// File: tb/sv/nearest_ray_polygon_hit_top_tb.sv
module nearest_ray_polygon_hit_top_tb;
  import nrph_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 3000000;
  localparam int ONE = 1 << FRAC_BITS;

  logic               clk = 0;
  logic               rst = 1;
  logic               s_axis_tvalid = 0;
  logic               s_axis_tready;
  logic [TDATA_W-1:0] s_axis_tdata = '0;
  logic [1:0]         s_axis_tuser = OP_SPARE;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 0;
  logic [COORD_W-1:0] m_axis_tdata;
  logic               m_axis_tuser;
  logic               cfg_we = 0;
  logic [COUNT_W-1:0] cfg_wdata = '0;
  int                 fail_count, pending;
  int                 send_idle_pct = 16, recv_idle_pct = 87;
  int                 cycles = 0;

  always #5 clk = ~clk;

  nearest_ray_polygon_hit_top i_dut (.*);

  nearest_ray_polygon_hit_checker i_checker (.*);

  // Receiver back-pressure.
  always @(posedge clk) m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);

  // Run limit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL nearest_ray_polygon_hit_top");
      $finish;
    end
  end

  function automatic logic [TDATA_W-1:0] pack_request(int fi, int vi, int vc, int ax, int ay,
                                                      int az, int bx, int by, int bz, int skip);
    logic [TDATA_W-1:0] r;
    r = '0;
    r[5:0] = 6'(fi);
    r[7:6] = 2'(vi);
    r[10:8] = 3'(vc);
    r[42:11] = ax;
    r[74:43] = ay;
    r[106:75] = az;
    r[138:107] = bx;
    r[170:139] = by;
    r[202:171] = bz;
    r[209:203] = 7'(skip);
    return r;
  endfunction

  // Present one request, with an optional idle gap first.
  task automatic send_request(opcode_t op, logic [TDATA_W-1:0] data);
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tuser <= op;
    s_axis_tdata <= data;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // Drain all results, then write the face count while the block is idle.
  task automatic set_face_count(int n);
    s_axis_tvalid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (120) @(posedge clk);
    cfg_we <= 1;
    cfg_wdata <= COUNT_W'(n);
    @(posedge clk);
    cfg_we <= 0;
    @(posedge clk);
  endtask

  function automatic int rnd_fx(int span);
    return $signed($urandom_range(2 * span * ONE)) - span * ONE;
  endfunction

  // An axis-aligned square or triangle with either winding.
  task automatic load_face(int f);
    int axis, sgn, p, cu, cv, w, n, vu[4], vv[4], pt[3];
    axis = $urandom_range(2);
    sgn = $urandom_range(1) ? 1 : -1;
    p = rnd_fx(30);
    cu = rnd_fx(10);
    cv = rnd_fx(10);
    w = $urandom_range(2 * ONE, 16 * ONE);
    n = $urandom_range(3) == 0 ? 3 : 4;
    vu = '{cu - w, cu + w, cu + w, cu - w};
    vv = '{cv - w, cv - w, cv + w, cv + w};
    for (int k = 0; k < 4; k++) begin
      int kk;
      kk = sgn > 0 ? k : 3 - k;
      pt[axis] = p;
      pt[axis == 0 ? 1 : 0] = vu[kk];
      pt[axis == 2 ? 1 : 2] = vv[kk];
      send_request(OP_VERTEX, pack_request(f, k, 0, pt[0], pt[1], pt[2], 0, 0, 0, 0));
    end
    pt = '{0, 0, 0};
    pt[axis] = sgn * ONE;
    send_request(OP_PLANE, pack_request(f, 0, n, pt[0], pt[1], pt[2], sgn * p, 0, 0, 0));
  endtask

  task automatic random_cast();
    send_request(OP_CAST, pack_request($urandom, $urandom, $urandom, rnd_fx(8), rnd_fx(8),
                 rnd_fx(8), rnd_fx(40), rnd_fx(40), rnd_fx(40),
                 $urandom_range(3) == 0 ? $urandom_range(127) : 64));
  endtask

  // Fully random request: any opcode and any bit pattern.
  task automatic noise_request();
    send_request(opcode_t'($urandom_range(3)),
                 pack_request($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                              $urandom, $urandom, $urandom, $urandom));
  endtask

  task automatic random_mix(int n);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(9))
        0: noise_request();
        1: load_face($urandom_range(MAX_FACES - 1));
        default: random_cast();
      endcase
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Fill the whole table so no cast reads an unwritten entry.
    for (int f = 0; f < MAX_FACES; f++) load_face(f);

    // Directed: empty table, then plane extremes and special cases.
    set_face_count(0);
    random_cast();
    set_face_count(1);
    // Plane z = 30 with a tiny step toward it: time saturates.
    send_request(OP_PLANE, pack_request(0, 0, 0, 0, 0, ONE, 30 * ONE, 0, 0, 0));
    send_request(OP_CAST, pack_request(0, 0, 0, 0, 0, 0, 0, 0, 7, 64));
    // Zero-length segment is parallel to every plane.
    send_request(OP_CAST, pack_request(0, 0, 0, 5, 5, 5, 5, 5, 5, 64));
    // Segment crossing the plane at half length.
    send_request(OP_CAST, pack_request(0, 0, 0, 0, 0, 0, 0, 0, 60 * ONE, 64));
    send_request(OP_CAST, pack_request(0, 0, 0, 0, 0, 0, 0, 0, 60 * ONE, 0));
    // Coordinate extremes saturate the direction.
    send_request(OP_CAST, pack_request(0, 0, 0, 32'h80000000, 32'h80000000, 32'h80000000,
                 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 64));
    send_request(OP_CAST, pack_request(0, 0, 0, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                 32'h80000000, 32'h80000000, 32'h80000000, 127));
    // Corner counts above the table size and degenerate counts.
    send_request(OP_PLANE, pack_request(0, 0, 7, 0, 0, ONE, 30 * ONE, 0, 0, 0));
    send_request(OP_CAST, pack_request(0, 0, 0, 0, 0, 0, ONE, ONE, 60 * ONE, 64));
    send_request(OP_PLANE, pack_request(0, 0, 2, 0, 0, -ONE, -30 * ONE, 0, 0, 0));
    send_request(OP_CAST, pack_request(0, 0, 0, 0, 0, 0, ONE, ONE, 60 * ONE, 64));
    send_request(OP_PLANE, pack_request(0, 0, 1, ONE, ONE, ONE, 10 * ONE, 0, 0, 0));
    send_request(OP_CAST, pack_request(0, 0, 0, 0, 0, 0, 9 * ONE, 9 * ONE, 9 * ONE, 64));
    // Unused opcode is ignored.
    send_request(OP_SPARE, pack_request(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    load_face(0);

    // Random phases under changing idling and face counts.
    set_face_count(MAX_FACES);
    random_mix(120);
    set_face_count($urandom_range(2, 63));
    send_idle_pct = 87;
    recv_idle_pct = 16;
    random_mix(110);
    set_face_count(127);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_mix(90);
    set_face_count($urandom_range(65, 126));
    random_mix(45);

    // Wait for the last results, then a margin for the pipeline.
    s_axis_tvalid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (150) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS nearest_ray_polygon_hit_top");
    end else begin
      $display("FAIL nearest_ray_polygon_hit_top");
    end
    $finish;
  end

endmodule
